[src/ptq_pkg.sv]
// types, constants and codes shared by the periodic timer queue
// no dependencies
`default_nettype none
package ptq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int ID_BITS_DEF    = 8;
  localparam int MAX_FIRE       = 16;
  localparam int DIVIDEND_W     = 52;
  localparam int USEC_W         = 20;

  localparam logic [47:0] MAX_TICK     = 48'hFFFF_FFFF_FFFF;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [19:0] DEFAULT_USEC = 20'd10000;

  typedef enum logic [1:0] {
    KIND_ATTACH_TICKS = 2'd0,
    KIND_ATTACH_SEC1  = 2'd1,
    KIND_ATTACH_SECS  = 2'd2,
    KIND_TICK         = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_FIRED    = 3'd0,
    ST_ATTACHED = 3'd1,
    ST_FULL     = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_t;

  typedef enum logic {
    REG_RUNNING = 1'b0,
    REG_USEC    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LOAD = 2'd1,
    OP_FIRE = 2'd2
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVGO,
    S_DIV,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  timer_id;
    logic [31:0] delay;
    logic        periodic;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  fired_id;
    logic [47:0] tick_count;
    logic        last;
  } result_t;

  // write command broadcast to the cells
  typedef struct packed {
    cell_op_t    op;
    logic [47:0] due;
    logic [47:0] period;
    logic        rpt;
    logic [15:0] order;
  } cell_wr_t;

  // best candidate and first free entry, handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [47:0] due;
    logic [15:0] age;
    logic        rpt;
    logic        free_found;
  } cand_t;

endpackage
`default_nettype wire

[src/ptq_div.sv]
// restoring divider, one quotient bit per cycle
// depends on ptq_pkg
`default_nettype none
module ptq_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptq_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [ptq_pkg::USEC_W-1:0]     divisor,
  output logic                          done,
  output logic [ptq_pkg::DIVIDEND_W-1:0] quotient
);
  import ptq_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] q;
  logic [USEC_W-1:0]     rem;
  logic [USEC_W-1:0]     dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [USEC_W:0]       sh;
  logic                  ge;

  assign sh       = {rem, q[DIVIDEND_W-1]};
  assign ge       = sh >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (ge) begin
          rem <= USEC_W'(sh - {1'b0, dvs});
        end else begin
          rem <= sh[USEC_W-1:0];
        end
        q <= {q[DIVIDEND_W-2:0], ge};
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/ptq_cell.sv]
// one timer entry; merges its entry into the candidate passed along the row
// depends on ptq_pkg
`default_nettype none
module ptq_cell #(
  parameter int ID_BITS  = ptq_pkg::ID_BITS_DEF,
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          order_count,
  input  logic [47:0]          tick,
  input  ptq_pkg::cell_wr_t    wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [ID_BITS-1:0]   wr_ident,
  input  ptq_pkg::cand_t       cand_in,
  input  logic [IDX_W-1:0]     cand_in_idx,
  input  logic [ID_BITS-1:0]   cand_in_ident,
  input  logic [IDX_W-1:0]     cand_in_free,
  output ptq_pkg::cand_t       cand_out,
  output logic [IDX_W-1:0]     cand_out_idx,
  output logic [ID_BITS-1:0]   cand_out_ident,
  output logic [IDX_W-1:0]     cand_out_free
);
  import ptq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic               valid;
  logic [47:0]        due;
  logic [47:0]        period;
  logic [ID_BITS-1:0] ident;
  logic               rpt;
  logic [15:0]        order;

  logic        hit;
  logic        eligible;
  logic        better;
  logic        take_free;
  logic [15:0] age;
  logic [48:0] next_due;

  assign hit       = wr_idx == MY_IDX;
  assign age       = order_count - order;
  assign eligible  = valid && (due <= tick);
  assign better    = eligible && (!cand_in.found || due < cand_in.due ||
                     (due == cand_in.due && age > cand_in.age));
  assign take_free = !valid && !cand_in.free_found;
  assign next_due  = {1'b0, due} + {1'b0, period};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (hit && wr.op == OP_LOAD) begin
      valid  <= 1'b1;
      due    <= wr.due;
      period <= wr.period;
      ident  <= wr_ident;
      rpt    <= wr.rpt;
      order  <= wr.order;
    end else if (hit && wr.op == OP_FIRE) begin
      if (rpt) begin
        due   <= next_due[48] ? MAX_TICK : next_due[47:0];
        order <= wr.order;
      end else begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.found      <= 1'b0;
      cand_out.free_found <= 1'b0;
    end else begin
      if (better) begin
        cand_out.found <= 1'b1;
        cand_out.due   <= due;
        cand_out.age   <= age;
        cand_out.rpt   <= rpt;
        cand_out_idx   <= MY_IDX;
        cand_out_ident <= ident;
      end else begin
        cand_out.found <= cand_in.found;
        cand_out.due   <= cand_in.due;
        cand_out.age   <= cand_in.age;
        cand_out.rpt   <= cand_in.rpt;
        cand_out_idx   <= cand_in_idx;
        cand_out_ident <= cand_in_ident;
      end
      cand_out.free_found <= cand_in.free_found || take_free;
      cand_out_free       <= take_free ? MY_IDX : cand_in_free;
    end
  end

endmodule
`default_nettype wire

[src/periodic_timer_queue_unit.sv]
// top level of the periodic timer queue: control, registers, cell row
// depends on ptq_pkg, ptq_cell, ptq_div
`default_nettype none
// Holds up to NUM_TIMERS timers in a row of cells. Every search (free entry
// for an attach, earliest due timer for a tick) is a wave that passes the row
// one cell per cycle. An attach in seconds first starts the divider and waits
// for its 52-step divide. A tick makes one search per firing plus one more, so
// up to 17 searches when 16 timers fire. A stalled output holds the unit up.
// One item is worked at a time; a finished result sits in the output register
// while the next item is taken.
module periodic_timer_queue_unit #(
  parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF,
  parameter int ID_BITS    = ptq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptq_pkg::item_t      item,
  input  logic                item_valid,
  output logic                item_stall,
  output ptq_pkg::result_t    result,
  output logic                result_valid,
  input  logic                result_stall,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data
);
  import ptq_pkg::*;

  localparam int IDX_W  = $clog2(NUM_TIMERS);
  localparam int SCAN_W = $clog2(NUM_TIMERS + 1);
  localparam int NF_W   = $clog2(MAX_FIRE + 1);

  state_t state, state_next;

  logic              running;
  logic [19:0]       usec;
  logic [47:0]       tick_counter;
  logic [15:0]       order_counter;
  item_t             cur;
  logic [47:0]       dly;
  logic [SCAN_W-1:0] scan_cnt;
  logic [NF_W-1:0]   nfired;
  logic              pend;
  logic [ID_BITS-1:0] pend_id;
  status_t           res_status;
  logic [ID_BITS-1:0] res_id;

  logic              accept;
  logic              out_free;
  logic              is_attach;
  logic              fire_go;
  logic              load_out;
  logic [15:0]       id_wide;
  logic [ID_BITS-1:0] in_id;
  logic [19:0]       usec_eff;
  logic [DIVIDEND_W-1:0] dividend;
  logic              div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic [47:0]       q_sat;
  logic [48:0]       load_sum;

  cell_wr_t           wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [ID_BITS-1:0] wr_ident;

  cand_t              cand [0:NUM_TIMERS];
  logic [IDX_W-1:0]   cidx [0:NUM_TIMERS];
  logic [ID_BITS-1:0] cident [0:NUM_TIMERS];
  logic [IDX_W-1:0]   cfree [0:NUM_TIMERS];
  cand_t              win;

  assign accept     = item_valid && !item_stall;
  assign item_stall = state != S_IDLE;
  assign out_free   = !result_valid || !result_stall;
  assign is_attach  = cur.kind != KIND_TICK;
  assign id_wide    = {8'd0, item.timer_id};
  assign in_id      = id_wide[ID_BITS-1:0];
  assign usec_eff   = (usec == '0) ? DEFAULT_USEC : usec;
  assign dividend   = (cur.kind == KIND_ATTACH_SEC1) ? DIVIDEND_W'(USEC_PER_SEC)
                      : DIVIDEND_W'({20'd0, cur.delay} * USEC_PER_SEC);
  assign q_sat      = (quotient[DIVIDEND_W-1:48] != '0) ? MAX_TICK : quotient[47:0];
  assign load_sum   = {1'b0, tick_counter} + {1'b0, dly};
  assign win        = cand[NUM_TIMERS];
  assign fire_go    = (state == S_DECIDE) && !is_attach && win.found &&
                      (nfired != NF_W'(MAX_FIRE)) && (!pend || out_free);
  assign load_out   = ((state == S_EMIT) && out_free) || (fire_go && pend);

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      usec    <= DEFAULT_USEC;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RUNNING: running <= cfg_data[0];
        REG_USEC:    usec    <= cfg_data;
        default:     usec    <= usec;
      endcase
    end
  end

  ptq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVGO),
    .dividend (dividend),
    .divisor  (usec_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // cell row
  assign cand[0]   = '0;
  assign cidx[0]   = '0;
  assign cident[0] = '0;
  assign cfree[0]  = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    ptq_cell #(
      .ID_BITS  (ID_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .order_count    (order_counter),
      .tick           (tick_counter),
      .wr             (wr),
      .wr_idx         (wr_idx),
      .wr_ident       (wr_ident),
      .cand_in        (cand[g]),
      .cand_in_idx    (cidx[g]),
      .cand_in_ident  (cident[g]),
      .cand_in_free   (cfree[g]),
      .cand_out       (cand[g+1]),
      .cand_out_idx   (cidx[g+1]),
      .cand_out_ident (cident[g+1]),
      .cand_out_free  (cfree[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    wr_idx     = '0;
    wr_ident   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.kind == KIND_TICK) begin
            state_next = S_SCAN;
          end else if (!running) begin
            state_next = S_EMIT;
          end else if (item.kind == KIND_ATTACH_TICKS) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DIVGO;
          end
        end
      end
      S_DIVGO: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == SCAN_W'(NUM_TIMERS)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (is_attach) begin
          state_next = S_EMIT;
          if (win.free_found) begin
            wr.op     = OP_LOAD;
            wr.due    = load_sum[48] ? MAX_TICK : load_sum[47:0];
            wr.period = dly;
            wr.rpt    = cur.periodic;
            wr.order  = order_counter;
            wr_idx    = cfree[NUM_TIMERS];
            wr_ident  = res_id;
          end
        end else if (win.found && nfired != NF_W'(MAX_FIRE)) begin
          if (!pend || out_free) begin
            state_next = S_SCAN;
            wr.op      = OP_FIRE;
            wr.order   = order_counter;
            wr_idx     = cidx[NUM_TIMERS];
          end
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      order_counter <= '0;
      scan_cnt      <= '0;
      nfired        <= '0;
      pend          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur      <= item;
            dly      <= (item.delay == '0) ? 48'd1 : 48'(item.delay);
            scan_cnt <= '0;
            nfired   <= '0;
            pend     <= 1'b0;
            res_id   <= in_id;
            if (item.kind == KIND_TICK) begin
              tick_counter <= tick_counter + 1'b1;
            end else if (!running) begin
              res_status <= ST_STOPPED;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            dly <= (q_sat == '0) ? 48'd1 : q_sat;
          end
        end
        S_SCAN: scan_cnt <= scan_cnt + 1'b1;
        S_DECIDE: begin
          if (is_attach) begin
            if (win.free_found) begin
              res_status    <= ST_ATTACHED;
              order_counter <= order_counter + 1'b1;
            end else begin
              res_status <= ST_FULL;
            end
          end else if (win.found && nfired != NF_W'(MAX_FIRE)) begin
            if (!pend || out_free) begin
              if (pend) begin
                // earlier firing goes out now that another one follows
                result.status       <= ST_FIRED;
                result.fired_id     <= 8'(16'(pend_id));
                result.tick_count   <= tick_counter;
                result.last         <= 1'b0;
              end
              pend     <= 1'b1;
              pend_id  <= cident[NUM_TIMERS];
              nfired   <= nfired + 1'b1;
              scan_cnt <= '0;
              if (win.rpt) begin
                order_counter <= order_counter + 1'b1;
              end
            end
          end else if (pend) begin
            res_status <= ST_FIRED;
            res_id     <= pend_id;
          end else begin
            res_status <= ST_NONE_DUE;
            res_id     <= '0;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.status     <= res_status;
            result.fired_id   <= 8'(16'(res_id));
            result.tick_count <= tick_counter;
            result.last       <= 1'b1;
          end
        end
        default: scan_cnt <= scan_cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

[test/periodic_timer_queue_unit_tb.sv]
// testbench for periodic_timer_queue_unit: directed table, then random phases
// checked against an in-bench model of the timer queue; depends on ptq_pkg
module periodic_timer_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptq_pkg::*;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  item_t item = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  result_t result;
  logic result_valid;
  logic result_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;

  periodic_timer_queue_unit dut (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid), .item_stall(item_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // timer queue shadow
  bit          run_q;
  logic [19:0] usec_q;
  logic [47:0] ticks_q;
  logic [15:0] seq_q;
  bit          armed[SLOTS];
  logic [47:0] due_q[SLOTS];
  logic [47:0] period_q[SLOTS];
  logic [7:0]  id_q[SLOTS];
  bit          rearm_q[SLOTS];
  logic [15:0] seq_of[SLOTS];

  result_t pending[$];
  int errors = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  function automatic logic [47:0] clamp48(logic [63:0] v);
    return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
  endfunction

  function automatic result_t mk(status_t st, logic [7:0] id, logic lst);
    result_t r;
    r.status = st;
    r.fired_id = id;
    r.tick_count = ticks_q;
    r.last = lst;
    return r;
  endfunction

  // works out the results of one request and queues them
  function automatic void arm_or_tick(item_t it);
    logic [63:0] span;
    logic [63:0] div;
    logic [15:0] age;
    logic [15:0] best_age;
    int slot;
    int best;
    int n;
    if (it.kind != KIND_TICK) begin
      if (!run_q) begin
        pending.push_back(mk(ST_STOPPED, it.timer_id, 1'b1));
        return;
      end
      div = (usec_q == 0) ? 64'd10000 : {44'd0, usec_q};
      if (it.kind == KIND_ATTACH_TICKS) span = {32'd0, it.delay};
      else if (it.kind == KIND_ATTACH_SEC1) span = 64'd1000000 / div;
      else span = clamp48({32'd0, it.delay} * 64'd1000000 / div);
      if (span == 0) span = 1;
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!armed[i] && slot < 0) slot = i;
      if (slot < 0) begin
        pending.push_back(mk(ST_FULL, it.timer_id, 1'b1));
        return;
      end
      armed[slot] = 1;
      due_q[slot] = clamp48({16'd0, ticks_q} + span);
      period_q[slot] = span[47:0];
      id_q[slot] = it.timer_id;
      rearm_q[slot] = it.periodic;
      seq_of[slot] = seq_q;
      seq_q++;
      pending.push_back(mk(ST_ATTACHED, it.timer_id, 1'b1));
      return;
    end
    ticks_q = ticks_q + 48'd1;
    n = 0;
    while (n < MAX_FIRE) begin
      best = -1;
      best_age = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (armed[i] && due_q[i] <= ticks_q) begin
          age = seq_q - seq_of[i];
          if (best < 0 || due_q[i] < due_q[best] ||
              (due_q[i] == due_q[best] && age > best_age)) begin
            best = i;
            best_age = age;
          end
        end
      end
      if (best < 0) break;
      pending.push_back(mk(ST_FIRED, id_q[best], 1'b0));
      n++;
      if (rearm_q[best]) begin
        due_q[best] = clamp48({16'd0, due_q[best]} + {16'd0, period_q[best]});
        seq_of[best] = seq_q;
        seq_q++;
      end else begin
        armed[best] = 0;
      end
    end
    if (n == 0) pending.push_back(mk(ST_NONE_DUE, 8'd0, 1'b1));
    else pending[$].last = 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        report("unexpected result", result, 0);
      end else begin
        w = pending.pop_front();
        if (result.status != w.status) report("status", result.status, w.status);
        if (result.fired_id != w.fired_id) report("fired_id", result.fired_id, w.fired_id);
        if (result.tick_count != w.tick_count)
          report("tick_count", result.tick_count, w.tick_count);
        if (result.last != w.last) report("last", result.last, w.last);
      end
    end
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side: random stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  task automatic cfg_write(reg_index_t idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_RUNNING) run_q = val[0];
    else usec_q = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(item_t it);
    while ($urandom_range(99) < snd_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    arm_or_tick(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.timer_id = $urandom;
    it.periodic = ($urandom_range(99) < 7);
    if ($urandom_range(99) < 45) begin
      it.kind = KIND_TICK;
      it.delay = $urandom;
    end else begin
      it.kind = kind_t'($urandom_range(2));
      if ($urandom_range(29) == 0) begin
        // far-off one-shot timer, walks the upper delay bits
        it.delay = $urandom;
        it.periodic = 1'b0;
      end else begin
        it.delay = (it.kind == KIND_ATTACH_SECS) ? $urandom_range(2) : $urandom_range(12);
      end
    end
    return it;
  endfunction

  typedef struct {
    int     phase;
    item_t  req;
    int     reps;
    bit     typed;
    status_t st;
  } row_t;

  row_t rows[] = '{
    // stopped: attaches refused, first tick has nothing due
    '{0, '{KIND_ATTACH_TICKS, 8'hFF, 32'hFFFF_FFFF, 1'b1}, 1, 1, ST_STOPPED},
    '{0, '{KIND_ATTACH_SECS, 8'h00, 32'h0, 1'b0}, 1, 1, ST_STOPPED},
    '{0, '{KIND_ATTACH_SEC1, 8'h55, 32'h0, 1'b0}, 1, 1, ST_STOPPED},
    '{0, '{KIND_TICK, 8'h00, 32'h0, 1'b0}, 1, 1, ST_NONE_DUE},
    // zero delay becomes one tick; fill every entry, then one more
    '{1, '{KIND_ATTACH_TICKS, 8'h3C, 32'h0, 1'b0}, 16, 0, ST_ATTACHED},
    '{1, '{KIND_ATTACH_TICKS, 8'h77, 32'h5, 1'b0}, 1, 1, ST_FULL},
    '{1, '{KIND_TICK, 8'h00, 32'h0, 1'b0}, 1, 0, ST_FIRED},
    '{1, '{KIND_ATTACH_SEC1, 8'h10, 32'h0, 1'b0}, 1, 0, ST_ATTACHED},
    '{1, '{KIND_ATTACH_SECS, 8'h20, 32'h3, 1'b1}, 1, 0, ST_ATTACHED},
    '{1, '{KIND_ATTACH_TICKS, 8'h30, 32'h3, 1'b0}, 1, 0, ST_ATTACHED},
    '{1, '{KIND_TICK, 8'h00, 32'h0, 1'b0}, 4, 0, ST_FIRED},
    // large delays at one microsecond per tick; the one in seconds saturates
    '{2, '{KIND_ATTACH_SECS, 8'hFE, 32'hFFFF_FFFF, 1'b0}, 1, 1, ST_ATTACHED},
    '{2, '{KIND_ATTACH_TICKS, 8'h01, 32'hFFFF_FFFF, 1'b0}, 1, 1, ST_ATTACHED},
    '{2, '{KIND_TICK, 8'h00, 32'h0, 1'b0}, 2, 0, ST_FIRED}
  };

  task automatic random_phase(int n, int s_pct, int r_pct, bit hold);
    snd_pct = s_pct;
    rcv_pct = r_pct;
    if (hold) hold_req = 1;
    for (int k = 0; k < n; k++) send(rand_item());
    drain();
  endtask

  initial begin
    int cur;
    run_q = 0;
    usec_q = 20'd10000;
    ticks_q = '0;
    seq_q = '0;
    foreach (armed[i]) armed[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(REG_RUNNING, 20'd0);
    cur = 0;
    foreach (rows[r]) begin
      if (rows[r].phase != cur) begin
        drain();
        cur = rows[r].phase;
        if (cur == 1) begin
          cfg_write(REG_RUNNING, 20'd1);
          cfg_write(REG_USEC, 20'd1000000);
        end else begin
          cfg_write(REG_USEC, 20'd1);
        end
      end
      for (int k = 0; k < rows[r].reps; k++) begin
        send(rows[r].req);
        if (rows[r].typed) pending[$].status = rows[r].st;
      end
    end
    drain();
    cfg_write(REG_USEC, 20'd1000000);
    random_phase(45, 33, 84, 0);
    cfg_write(REG_USEC, 20'd0);
    random_phase(45, 84, 33, 0);
    cfg_write(REG_USEC, 20'd250000);
    random_phase(45, 0, 0, 1);
    cfg_write(REG_RUNNING, 20'd0);
    cfg_write(REG_USEC, 20'd1);
    random_phase(16, 0, 0, 0);
    cfg_write(REG_RUNNING, 20'd1);
    cfg_write(REG_USEC, 20'd1000000);
    random_phase(25, 0, 0, 0);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[periodic_timer_queue_unit.f]
src/ptq_pkg.sv
src/ptq_div.sv
src/ptq_cell.sv
src/periodic_timer_queue_unit.sv
test/periodic_timer_queue_unit_tb.sv
